@@ src/ffba_pkg.sv @@
// Shared types and codes for the first-fit block allocator.
// Used by ffba_ctrl, ffba_dpath and the top level; depends on nothing.
`default_nettype none
package ffba_pkg;

   localparam int unsigned ADDR_W = 11;
   localparam int unsigned STAT_W = 3;

   // request kinds
   localparam logic [1:0] KIND_RESET = 2'd0;
   localparam logic [1:0] KIND_ALLOC = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;
   localparam logic [1:0] KIND_GET   = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_RESET_DONE = 3'd0;
   localparam logic [STAT_W-1:0] ST_ALLOCATED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_ALLOC_REJ  = 3'd2;
   localparam logic [STAT_W-1:0] ST_FREED      = 3'd3;
   localparam logic [STAT_W-1:0] ST_FREE_REJ   = 3'd4;
   localparam logic [STAT_W-1:0] ST_GOT        = 3'd5;
   localparam logic [STAT_W-1:0] ST_GET_REJ    = 3'd6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_READ,
      OP_STEP,
      OP_READ_IDX,
      OP_FOUND_ALLOC,
      OP_FOUND_FREE,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_INSERT,
      OP_DEL_RD,
      OP_DEL_WR,
      OP_REMOVE,
      OP_GOT,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [STAT_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       len_zero;
      logic       at_end;
      logic       fit_end;
      logic       fit_mid;
      logic       past_addr;
      logic       contains;
      logic       idx_ok;
      logic       ins_done;
      logic       del_done;
   } flags_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
   } block_type;

endpackage
`default_nettype wire

@@ src/ffba_ctrl.sv @@
// Sequencer of the first-fit block allocator: steps the list scan, shift and reply.
// Depends on ffba_pkg.
`default_nettype none
module ffba_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire ffba_pkg::flags_type flags,
   output ffba_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_A_LOOK, S_A_CHK, S_INS_CHK, S_INS_WR,
      S_F_LOOK, S_F_CHK, S_DEL_CHK, S_DEL_WR, S_G_OUT, S_RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [ffba_pkg::STAT_W-1:0]   status_ff, status_in;

   // decode next state and datapath command
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd.op     = ffba_pkg::OP_NONE;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = ffba_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (flags.kind)
               ffba_pkg::KIND_RESET: begin
                  cmd.op    = ffba_pkg::OP_CLEAR;
                  status_in = ffba_pkg::ST_RESET_DONE;
                  state_in  = S_RESP;
               end
               ffba_pkg::KIND_ALLOC: begin
                  if (flags.len_zero) begin
                     status_in = ffba_pkg::ST_ALLOC_REJ;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_A_LOOK;
                  end
               end
               ffba_pkg::KIND_FREE: state_in = S_F_LOOK;
               default: begin
                  if (flags.idx_ok) begin
                     cmd.op   = ffba_pkg::OP_READ_IDX;
                     state_in = S_G_OUT;
                  end else begin
                     status_in = ffba_pkg::ST_GET_REJ;
                     state_in  = S_RESP;
                  end
               end
            endcase
         end
         // walk gaps between listed blocks
         S_A_LOOK: begin
            if (flags.at_end) begin
               if (flags.fit_end) begin
                  cmd.op   = ffba_pkg::OP_FOUND_ALLOC;
                  state_in = S_INS_CHK;
               end else begin
                  status_in = ffba_pkg::ST_ALLOC_REJ;
                  state_in  = S_RESP;
               end
            end else begin
               cmd.op   = ffba_pkg::OP_READ;
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (flags.fit_mid) begin
               cmd.op   = ffba_pkg::OP_FOUND_ALLOC;
               state_in = S_INS_CHK;
            end else begin
               cmd.op   = ffba_pkg::OP_STEP;
               state_in = S_A_LOOK;
            end
         end
         // open a slot by shifting entries up
         S_INS_CHK: begin
            if (flags.ins_done) begin
               cmd.op    = ffba_pkg::OP_INSERT;
               status_in = ffba_pkg::ST_ALLOCATED;
               state_in  = S_RESP;
            end else begin
               cmd.op   = ffba_pkg::OP_SHIFT_RD;
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.op   = ffba_pkg::OP_SHIFT_WR;
            state_in = S_INS_CHK;
         end
         // search the block that holds the address
         S_F_LOOK: begin
            if (flags.at_end) begin
               status_in = ffba_pkg::ST_FREE_REJ;
               state_in  = S_RESP;
            end else begin
               cmd.op   = ffba_pkg::OP_READ;
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (flags.past_addr) begin
               status_in = ffba_pkg::ST_FREE_REJ;
               state_in  = S_RESP;
            end else if (flags.contains) begin
               cmd.op   = ffba_pkg::OP_FOUND_FREE;
               state_in = S_DEL_CHK;
            end else begin
               cmd.op   = ffba_pkg::OP_STEP;
               state_in = S_F_LOOK;
            end
         end
         // close the gap by shifting entries down
         S_DEL_CHK: begin
            if (flags.del_done) begin
               cmd.op    = ffba_pkg::OP_REMOVE;
               status_in = ffba_pkg::ST_FREED;
               state_in  = S_RESP;
            end else begin
               cmd.op   = ffba_pkg::OP_DEL_RD;
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.op   = ffba_pkg::OP_DEL_WR;
            state_in = S_DEL_CHK;
         end
         S_G_OUT: begin
            cmd.op    = ffba_pkg::OP_GOT;
            status_in = ffba_pkg::ST_GOT;
            state_in  = S_RESP;
         end
         S_RESP: begin
            cmd.op   = ffba_pkg::OP_RESPOND;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ffba_pkg::ST_RESET_DONE;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

@@ src/ffba_dpath.sv @@
// Datapath of the first-fit block allocator: sorted block list memory, scan
// registers, gap compares and result registers. Depends on ffba_pkg.
`default_nettype none
module ffba_dpath #(
   parameter int unsigned MAX_UNITS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ffba_pkg::cmd_type           cmd,
   output ffba_pkg::flags_type              flags,
   input  wire logic [1:0]                  req_kind,
   input  wire logic [ffba_pkg::ADDR_W-1:0] req_request_length,
   input  wire logic [ffba_pkg::ADDR_W-1:0] req_free_address,
   input  wire logic [ffba_pkg::ADDR_W-1:0] req_block_index,
   input  wire logic                        csr_write,
   input  wire logic [ffba_pkg::ADDR_W-1:0] csr_wdata,
   output logic                             rsp_strobe,
   output logic [ffba_pkg::STAT_W-1:0]      rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0]      rsp_start_address,
   output logic [ffba_pkg::ADDR_W-1:0]      rsp_end_address
);

   localparam int unsigned IW = $clog2(MAX_UNITS);
   localparam int unsigned CW = $clog2(MAX_UNITS + 1);
   localparam int unsigned AW = ffba_pkg::ADDR_W;
   localparam logic [31:0] MAX32 = MAX_UNITS;

   ffba_pkg::block_type mem [MAX_UNITS];
   ffba_pkg::block_type rd_ff;

   logic [AW-1:0] mu_ff, mu_in;
   logic [CW-1:0] count_ff, p_ff, q_ff;
   logic [1:0]    kind_ff;
   logic [AW-1:0] len_ff, addr_ff, idx_ff, prev_ff, res_s_ff, res_e_ff;
   logic          rsp_strobe_ff;
   logic [ffba_pkg::STAT_W-1:0] rsp_status_ff;
   logic [AW-1:0] rsp_s_ff, rsp_e_ff;

   logic [AW:0]   gap_end, gap_mid;
   logic [CW-1:0] qm1, qp1;
   logic [31:0]   idxm1;
   logic [AW-1:0] new_e;

   // clamp written unit count into 1..MAX_UNITS
   always_comb begin
      if (csr_wdata == '0)
         mu_in = AW'(1);
      else if (32'(csr_wdata) > MAX32)
         mu_in = AW'(MAX_UNITS);
      else
         mu_in = csr_wdata;
   end

   assign gap_end = {1'b0, mu_ff} - {1'b0, prev_ff};
   assign gap_mid = {1'b0, rd_ff.start_addr} - {1'b0, prev_ff};
   assign qm1     = q_ff - CW'(1);
   assign qp1     = q_ff + CW'(1);
   assign idxm1   = 32'(idx_ff) - 32'd1;
   assign new_e   = prev_ff + len_ff;

   // status to the sequencer
   always_comb begin
      flags.kind      = kind_ff;
      flags.len_zero  = (len_ff == '0);
      flags.at_end    = (p_ff == count_ff);
      flags.fit_end   = (gap_end >= {1'b0, len_ff});
      flags.fit_mid   = (gap_mid > {1'b0, len_ff});
      flags.past_addr = (rd_ff.start_addr > addr_ff);
      flags.contains  = (rd_ff.end_addr >= addr_ff);
      flags.idx_ok    = (idx_ff != '0) && (32'(idx_ff) <= 32'(count_ff));
      flags.ins_done  = (q_ff == p_ff);
      flags.del_done  = (32'(qp1) >= 32'(count_ff));
   end

   // block list memory, registered read
   always_ff @(posedge clock) begin
      case (cmd.op)
         ffba_pkg::OP_READ:     rd_ff <= mem[p_ff[IW-1:0]];
         ffba_pkg::OP_READ_IDX: rd_ff <= mem[idxm1[IW-1:0]];
         ffba_pkg::OP_SHIFT_RD: rd_ff <= mem[qm1[IW-1:0]];
         ffba_pkg::OP_DEL_RD:   rd_ff <= mem[qp1[IW-1:0]];
         ffba_pkg::OP_SHIFT_WR: mem[q_ff[IW-1:0]] <= rd_ff;
         ffba_pkg::OP_DEL_WR:   mem[q_ff[IW-1:0]] <= rd_ff;
         ffba_pkg::OP_INSERT:   mem[p_ff[IW-1:0]] <= '{start_addr: res_s_ff,
                                                       end_addr: res_e_ff};
         default: ;
      endcase
   end

   // scan and result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         ffba_pkg::OP_LOAD: begin
            kind_ff  <= req_kind;
            len_ff   <= req_request_length;
            addr_ff  <= req_free_address;
            idx_ff   <= req_block_index;
            prev_ff  <= '0;
            p_ff     <= '0;
            res_s_ff <= '0;
            res_e_ff <= '0;
         end
         ffba_pkg::OP_STEP: begin
            prev_ff <= rd_ff.end_addr;
            p_ff    <= p_ff + CW'(1);
         end
         ffba_pkg::OP_FOUND_ALLOC: begin
            res_s_ff <= prev_ff + AW'(1);
            res_e_ff <= new_e;
            q_ff     <= count_ff;
         end
         ffba_pkg::OP_FOUND_FREE: begin
            res_s_ff <= rd_ff.start_addr;
            res_e_ff <= rd_ff.end_addr;
            q_ff     <= p_ff;
         end
         ffba_pkg::OP_SHIFT_WR: q_ff <= qm1;
         ffba_pkg::OP_DEL_WR:   q_ff <= qp1;
         ffba_pkg::OP_GOT:      res_s_ff <= rd_ff.start_addr;
         ffba_pkg::OP_RESPOND: begin
            rsp_status_ff <= cmd.status;
            rsp_s_ff      <= res_s_ff;
            rsp_e_ff      <= res_e_ff;
         end
         default: ;
      endcase
   end

   // control registers: unit count, block count, strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff         <= AW'(MAX_UNITS > 2047 ? 2047 : MAX_UNITS);
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.op == ffba_pkg::OP_RESPOND);
         if (csr_write) begin
            mu_ff    <= mu_in;
            count_ff <= '0;
         end else if (cmd.op == ffba_pkg::OP_CLEAR) begin
            count_ff <= '0;
         end else if (cmd.op == ffba_pkg::OP_INSERT) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.op == ffba_pkg::OP_REMOVE) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_start_address = rsp_s_ff;
   assign rsp_end_address   = rsp_e_ff;

endmodule
`default_nettype wire

@@ src/first_fit_block_allocator_top.sv @@
// Top level of the first-fit block allocator: sequencer plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dpath.
//
//   channel   handshake            payload
//   request   start, busy          req_kind, req_request_length,
//                                  req_free_address, req_block_index
//   response  rsp_strobe           rsp_status, rsp_start_address, rsp_end_address
//   config    csr_write            csr_wdata
//
// A request is taken when start is high and busy is low. Allocate and free scan
// the sorted block list entry by entry through the single list memory port, then
// shift entries one by one, each by a read and a write; busy stays high until the
// response. Reset, a zero length and a bad get index go straight to the response;
// a good get reads its entry first. The response strobe lasts one cycle and cannot
// be stalled. Synchronous reset empties the list at once (no clearing pass).
`default_nettype none
module first_fit_block_allocator_top #(
   parameter int unsigned MAX_UNITS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_kind,
   input  wire logic [ffba_pkg::ADDR_W-1:0] req_request_length,
   input  wire logic [ffba_pkg::ADDR_W-1:0] req_free_address,
   input  wire logic [ffba_pkg::ADDR_W-1:0] req_block_index,
   output logic                             rsp_strobe,
   output logic [ffba_pkg::STAT_W-1:0]      rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0]      rsp_start_address,
   output logic [ffba_pkg::ADDR_W-1:0]      rsp_end_address,
   input  wire logic                        csr_write,
   input  wire logic [ffba_pkg::ADDR_W-1:0] csr_wdata
);

   ffba_pkg::cmd_type   cmd;
   ffba_pkg::flags_type flags;

   ffba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   ffba_dpath #(.MAX_UNITS(MAX_UNITS)) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .flags              (flags),
      .req_kind           (req_kind),
      .req_request_length (req_request_length),
      .req_free_address   (req_free_address),
      .req_block_index    (req_block_index),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_start_address  (rsp_start_address),
      .rsp_end_address    (rsp_end_address)
   );

endmodule
`default_nettype wire
